### rtl/e2q_pkg.sv
// Package for the Euler-angle to quaternion converter: constants and helpers.
package e2q_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int AtanEntries = 24;
   localparam int AngleWidth = 16;
   localparam int QuatWidth = 16;
   // CORDIC datapath width (Q30 with headroom).
   localparam int CordicWidth = 34;
   // Residual angle width (units of 2^-16 degree).
   localparam int ThetaWidth = 26;

   localparam logic signed [ThetaWidth-1:0] Deg90 = 26'sd5898240;
   localparam logic signed [ThetaWidth-1:0] Deg180 = 26'sd11796480;
   localparam logic signed [CordicWidth-1:0] GainQ30 = 34'sd652032874;
   localparam logic signed [17:0] OneQ14 = 18'sd16384;

   // Arctangent of 2^-i in degrees times 2^16.
   function automatic logic signed [ThetaWidth-1:0] atan_lookup(input int idx);
      logic signed [ThetaWidth-1:0] val;
      begin
         case (idx)
            0: val = 26'sd2949120;
            1: val = 26'sd1740967;
            2: val = 26'sd919879;
            3: val = 26'sd466945;
            4: val = 26'sd234379;
            5: val = 26'sd117304;
            6: val = 26'sd58666;
            7: val = 26'sd29335;
            8: val = 26'sd14668;
            9: val = 26'sd7334;
            10: val = 26'sd3667;
            11: val = 26'sd1833;
            12: val = 26'sd917;
            13: val = 26'sd458;
            14: val = 26'sd229;
            15: val = 26'sd115;
            16: val = 26'sd57;
            17: val = 26'sd29;
            18: val = 26'sd14;
            19: val = 26'sd7;
            20: val = 26'sd4;
            21: val = 26'sd2;
            22: val = 26'sd1;
            default: val = '0;
         endcase
         atan_lookup = val;
      end
   endfunction

endpackage

### rtl/euler_to_quaternion.sv
// Euler angles to unit quaternion: pipelined CORDIC and product combiner.
// An accepted req beat passes the fold, rotation, round, product and sum stages to its rsp beat.
// Throughput: one beat per cycle when not stalled; every stage advances together and holds on stall.
// The pipeline is set by the CORDIC stage chain, one micro-rotation per stage.
// Reset clears only the stage valid bits; payload registers are not reset.
module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int CORDIC_STAGES = CordicStagesDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [AngleWidth-1:0] req_angle_x,
   input  logic signed [AngleWidth-1:0] req_angle_y,
   input  logic signed [AngleWidth-1:0] req_angle_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [QuatWidth-1:0]  rsp_quat_w,
   output logic signed [QuatWidth-1:0]  rsp_quat_x,
   output logic signed [QuatWidth-1:0]  rsp_quat_y,
   output logic signed [QuatWidth-1:0]  rsp_quat_z
);

   localparam int NumRot = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
   // Stage 0 fold, NumRot rotations, round, product 1, product 2, sum/round.
   localparam int NumStages = NumRot + 5;

   // Global advance: the pipeline moves when the output is free.
   logic advance;
   logic [NumStages-1:0] vld_ff, vld_in;
   assign advance = !(vld_ff[NumStages-1] && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      vld_in = {vld_ff[NumStages-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // CORDIC lanes: one per angle.
   logic signed [CordicWidth-1:0] cx_ff [3][NumRot+1];
   logic signed [CordicWidth-1:0] cy_ff [3][NumRot+1];
   logic signed [ThetaWidth-1:0]  th_ff [3][NumRot+1];
   logic                          ng_ff [3][NumRot+1];
   logic signed [17:0]            cos_ff [3];
   logic signed [17:0]            sin_ff [3];

   genvar a, s;
   generate
      for (a = 0; a < 3; a++) begin : g_lane
         logic signed [AngleWidth-1:0] ang;
         logic signed [ThetaWidth-1:0] th0;
         logic signed [ThetaWidth-1:0] th_fold_in;
         logic                         neg_in;
         assign ang = (a == 0) ? req_angle_x : ((a == 1) ? req_angle_y : req_angle_z);
         assign th0 = ThetaWidth'(ang) <<< 9;

         // Fold the half angle into +-90 degrees.
         always_comb begin
            th_fold_in = th0;
            neg_in = 1'b0;
            if (th0 > Deg90) begin
               th_fold_in = th0 - Deg180;
               neg_in = 1'b1;
            end else if (th0 < -Deg90) begin
               th_fold_in = th0 + Deg180;
               neg_in = 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               th_ff[a][0] <= th_fold_in;
               ng_ff[a][0] <= neg_in;
               cx_ff[a][0] <= GainQ30;
               cy_ff[a][0] <= '0;
            end
         end

         // One micro-rotation per stage; arithmetic shifts floor.
         for (s = 0; s < NumRot; s++) begin : g_rot
            logic signed [CordicWidth-1:0] dx, dy;
            assign dx = cy_ff[a][s] >>> s;
            assign dy = cx_ff[a][s] >>> s;
            always_ff @(posedge clock) begin
               if (advance) begin
                  ng_ff[a][s+1] <= ng_ff[a][s];
                  if (!th_ff[a][s][ThetaWidth-1]) begin
                     cx_ff[a][s+1] <= cx_ff[a][s] - dx;
                     cy_ff[a][s+1] <= cy_ff[a][s] + dy;
                     th_ff[a][s+1] <= th_ff[a][s] - atan_lookup(s);
                  end else begin
                     cx_ff[a][s+1] <= cx_ff[a][s] + dx;
                     cy_ff[a][s+1] <= cy_ff[a][s] - dy;
                     th_ff[a][s+1] <= th_ff[a][s] + atan_lookup(s);
                  end
               end
            end
         end

         // Apply fold sign, round Q30 to Q14 and saturate.
         logic signed [CordicWidth-1:0] fx, fy;
         logic signed [CordicWidth-1:0] rx, ry;
         assign fx = ng_ff[a][NumRot] ? -cx_ff[a][NumRot] : cx_ff[a][NumRot];
         assign fy = ng_ff[a][NumRot] ? -cy_ff[a][NumRot] : cy_ff[a][NumRot];
         assign rx = (fx + CordicWidth'(32768)) >>> 16;
         assign ry = (fy + CordicWidth'(32768)) >>> 16;
         always_ff @(posedge clock) begin
            if (advance) begin
               cos_ff[a] <= (rx > CordicWidth'(OneQ14)) ? OneQ14 :
                            (rx < -CordicWidth'(OneQ14)) ? -OneQ14 : rx[17:0];
               sin_ff[a] <= (ry > CordicWidth'(OneQ14)) ? OneQ14 :
                            (ry < -CordicWidth'(OneQ14)) ? -OneQ14 : ry[17:0];
            end
         end
      end
   endgenerate

   // First products: pairs of y and z terms (Q8.28), plus x terms carried.
   logic signed [35:0] cycz_ff, sysz_ff, sycz_ff, cysz_ff;
   logic signed [17:0] cx_d_ff, sx_d_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cycz_ff <= cos_ff[1] * cos_ff[2];
         sysz_ff <= sin_ff[1] * sin_ff[2];
         sycz_ff <= sin_ff[1] * cos_ff[2];
         cysz_ff <= cos_ff[1] * sin_ff[2];
         cx_d_ff <= cos_ff[0];
         sx_d_ff <= sin_ff[0];
      end
   end

   // Second products: exact Q12.42 terms.
   logic signed [53:0] p_ff [8];
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= cycz_ff * cx_d_ff;
         p_ff[1] <= sysz_ff * sx_d_ff;
         p_ff[2] <= sysz_ff * cx_d_ff;
         p_ff[3] <= cycz_ff * sx_d_ff;
         p_ff[4] <= sycz_ff * cx_d_ff;
         p_ff[5] <= cysz_ff * sx_d_ff;
         p_ff[6] <= cysz_ff * cx_d_ff;
         p_ff[7] <= sycz_ff * sx_d_ff;
      end
   end

   // Sum, round to Q14 and saturate each component.
   function automatic logic signed [QuatWidth-1:0] round_sat(input logic signed [54:0] v);
      logic signed [54:0] r;
      begin
         r = (v + 55'sd134217728) >>> 28;
         if (r > 55'sd16384) round_sat = 16'sd16384;
         else if (r < -55'sd16384) round_sat = -16'sd16384;
         else round_sat = r[QuatWidth-1:0];
      end
   endfunction

   logic signed [QuatWidth-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         qw_ff <= round_sat(55'(p_ff[0]) - 55'(p_ff[1]));
         qx_ff <= round_sat(55'(p_ff[2]) + 55'(p_ff[3]));
         qy_ff <= round_sat(55'(p_ff[4]) + 55'(p_ff[5]));
         qz_ff <= round_sat(55'(p_ff[6]) - 55'(p_ff[7]));
      end
   end

   assign rsp_valid = vld_ff[NumStages-1];
   assign rsp_quat_w = qw_ff;
   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;

   // A stalled output holds its valid and its w component.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_w))
      else $error("stalled beat changed");
   // Input is stalled exactly when output is stalled with a beat.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("stall mismatch");
   // The w result stays within unit range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_w <= 16'sd16384 && rsp_quat_w >= -16'sd16384))
      else $error("w out of range");
endmodule
